// ===== design/cie_pkg.sv =====
package cie_pkg;

    // Internal byte store
    localparam int MEM_BYTES = 65536;
    localparam int MEM_AW    = $clog2(MEM_BYTES);

    // Command codes
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_EXEC  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    // ALU operations, in opcode order
    typedef enum logic [2:0] {
        ALU_ADD = 3'd0,
        ALU_ADC = 3'd1,
        ALU_SUB = 3'd2,
        ALU_SBB = 3'd3,
        ALU_ANA = 3'd4,
        ALU_XRA = 3'd5,
        ALU_ORA = 3'd6,
        ALU_CMP = 3'd7
    } t_alu_op;

    // Half-carry tables, bit i indexed by {a[3], v[3], res[3]}
    localparam logic [7:0] ADD_HC = 8'b1101_0100;
    localparam logic [7:0] SUB_HB = 8'b1000_1110;

    localparam logic [7:0] DAA_LO   = 8'h06;
    localparam logic [7:0] DAA_HI   = 8'h60;
    localparam logic [7:0] OP_HLT   = 8'h76;
    localparam logic [7:0] RST_MASK = 8'h38;

    typedef struct packed {
        logic s;
        logic z;
        logic ac;
        logic p;
        logic cy;
    } t_flags;

    typedef struct packed {
        logic              we;
        logic [MEM_AW-1:0] addr;
        logic [7:0]        wdata;
    } t_mem_req;

    function automatic logic [7:0] f_flag_byte(input t_flags f);
        return {f.s, f.z, 1'b0, f.ac, 1'b0, f.p, 1'b1, f.cy};
    endfunction

endpackage

// ===== design/cie_if.sv =====
interface cie_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata;

    modport source (output valid, cmd, mem_addr, mem_wdata, input ready);
    modport sink   (input valid, cmd, mem_addr, mem_wdata, output ready);
endinterface

interface cie_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pc_value;
    logic [15:0] sp_value;
    logic [7:0]  a_value;
    logic [7:0]  b_value;
    logic [7:0]  c_value;
    logic [7:0]  d_value;
    logic [7:0]  e_value;
    logic [7:0]  h_value;
    logic [7:0]  l_value;
    logic [7:0]  flag_byte;
    logic        ints_enabled;
    logic [7:0]  read_byte;

    modport source (output valid, pc_value, sp_value, a_value, b_value, c_value, d_value,
                    e_value, h_value, l_value, flag_byte, ints_enabled, read_byte,
                    input ready);
    modport sink   (input valid, pc_value, sp_value, a_value, b_value, c_value, d_value,
                    e_value, h_value, l_value, flag_byte, ints_enabled, read_byte,
                    output ready);
endinterface

// ===== design/cie_ram.sv =====
module cie_ram import cie_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_mem_req   i_req,
    output logic [7:0] o_rdata,
    output logic       o_busy
);

    logic [7:0]        mem [MEM_BYTES];
    logic [MEM_AW-1:0] r_clr_addr;
    logic              r_busy;
    logic [7:0]        r_rdata;

    // clearing pass after reset, one byte a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_busy <= 1'b0;
            end
        end
    end

    // single port, registered read
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            mem[r_clr_addr] <= '0;
        end else if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= mem[i_req.addr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

// ===== design/cie_alu.sv =====
module cie_alu import cie_pkg::*; (
    input  t_alu_op    i_op,
    input  logic [7:0] i_a,
    input  logic [7:0] i_v,
    input  t_flags     i_fl,
    output logic [7:0] o_res,
    output t_flags     o_fl
);

    logic [8:0] sum;
    logic [8:0] sub;
    logic [7:0] res_add;
    logic [7:0] res_sub;
    logic [7:0] res;
    logic       ac;
    logic       cy;

    always_comb begin
        sum     = {1'b0, i_a} + {1'b0, i_v} + {8'd0, (i_op == ALU_ADC) & i_fl.cy};
        sub     = {1'b0, i_v} + {8'd0, (i_op == ALU_SBB) & i_fl.cy};
        res_add = sum[7:0];
        res_sub = i_a - sub[7:0];
        unique case (i_op) inside
            ALU_ADD, ALU_ADC: begin
                res = res_add;
                ac  = ADD_HC[{i_a[3], i_v[3], res_add[3]}];
                cy  = sum[8];
            end
            ALU_SUB, ALU_SBB, ALU_CMP: begin
                res = res_sub;
                ac  = ~SUB_HB[{i_a[3], i_v[3], res_sub[3]}];
                cy  = ({1'b0, i_a} < sub);
            end
            ALU_ANA: begin
                res = i_a & i_v;
                ac  = i_a[3] | i_v[3];
                cy  = 1'b0;
            end
            ALU_XRA: begin
                res = i_a ^ i_v;
                ac  = 1'b0;
                cy  = 1'b0;
            end
            ALU_ORA: begin
                res = i_a | i_v;
                ac  = 1'b0;
                cy  = 1'b0;
            end
        endcase
        o_res   = res;
        o_fl.s  = res[7];
        o_fl.z  = (res == 8'd0);
        o_fl.ac = ac;
        o_fl.p  = ~^res;
        o_fl.cy = cy;
    end

endmodule

// ===== design/cpu8080_instruction_execute_unit.sv =====
// Channel | Dir | Beat contents
// i_in    | in  | cmd, mem_addr, mem_wdata
// o_res   | out | pc, sp, A..L, flag byte, interrupt enable, read byte
//
// A write goes from idle to done, a read through S_RDB. An instruction has a state per fetch
// byte and per data byte on the single memory port, plus decode (S_EX) and commit (S_COM).
// After reset the memory clears all MEM_BYTES (65536) bytes; no beat is taken then.
// One command at a time; a new beat is taken while the previous result waits in the
// output register, and a stalled output holds the next result in its final state.
module cpu8080_instruction_execute_unit import cie_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cie_in_if.sink i_in,
    cie_out_if.source o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_RDB, S_OP, S_B2, S_B3, S_EX, S_R1, S_R2, S_COM, S_W2, S_DONE
    } t_state;

    typedef struct packed {
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [7:0]  fb;
        logic        ie;
        logic [7:0]  rb;
    } t_result;

    t_state      r_state;
    logic [15:0] r_pc, r_sp;
    logic [7:0]  r_a, r_b, r_c, r_d, r_e, r_h, r_l;
    t_flags      r_fl;
    logic        r_ie;
    logic [7:0]  r_op, r_b2, r_b3, r_lo, r_hi, r_rbyte, r_wd2;
    logic [15:0] r_ea, r_wa2;
    logic        r_rd2;
    logic        r_ov;
    t_result     r_res;

    logic [15:0] n_pc, n_sp;
    logic [7:0]  n_a, n_b, n_c, n_d, n_e, n_h, n_l;
    t_flags      n_fl;
    logic        n_ie;

    t_mem_req    ram_req;
    logic [7:0]  ram_rdata;
    logic        ram_busy;
    logic        in_beat;

    logic [2:0]  y, z;
    logic [1:0]  p, q;
    logic [15:0] hl, imm, mdat, pcn, rp, rp_new, push_val;
    logic [7:0]  src, opnd, v, adj, reg_val;
    logic [16:0] dad;
    logic        cond, rp_we, reg_we, push_we, daa_cy;
    logic [2:0]  reg_idx;
    logic        w1_we, w2_we;
    logic [15:0] w1_addr, w2_addr;
    logic [7:0]  w1_data, w2_data;
    logic [15:0] ex_ea;
    logic [1:0]  ex_nrd;
    t_alu_op     alu_op;
    logic [7:0]  alu_v, alu_res;
    t_flags      alu_fl;

    // instruction length from opcode
    function automatic logic [1:0] f_len(input logic [7:0] op);
        logic [1:0] len;
        len = 2'd1;
        unique case (op[7:6])
            2'd0: begin
                if ((op[2:0] == 3'd1 && !op[3]) || (op[2:0] == 3'd2 && op[5])) begin
                    len = 2'd3;
                end else if (op[2:0] == 3'd6) begin
                    len = 2'd2;
                end
            end
            2'd3: begin
                case (op[2:0])
                    3'd2, 3'd4: len = 2'd3;
                    3'd3: begin
                        if (op[5:3] == 3'd0) begin
                            len = 2'd3;
                        end else if (op[5:3] == 3'd2 || op[5:3] == 3'd3) begin
                            len = 2'd2;
                        end
                    end
                    3'd5: if (op[3] && op[5:4] == 2'd0) len = 2'd3;
                    3'd6: len = 2'd2;
                    default: len = 2'd1;
                endcase
            end
            default: len = 2'd1;
        endcase
        return len;
    endfunction

    cie_ram u_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ram_req),
        .o_rdata (ram_rdata),
        .o_busy  (ram_busy)
    );

    cie_alu u_alu (
        .i_op  (alu_op),
        .i_a   (r_a),
        .i_v   (alu_v),
        .i_fl  (r_fl),
        .o_res (alu_res),
        .o_fl  (alu_fl)
    );

    assign in_beat    = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE) && !ram_busy;

    // operand fields and shared values
    always_comb begin
        y    = r_op[5:3];
        z    = r_op[2:0];
        p    = r_op[5:4];
        q    = r_op[7:6];
        hl   = {r_h, r_l};
        imm  = {r_b3, r_b2};
        mdat = {r_hi, r_lo};
        pcn  = r_pc + {14'd0, f_len(r_op)};
        case (z)
            3'd0:    src = r_b;
            3'd1:    src = r_c;
            3'd2:    src = r_d;
            3'd3:    src = r_e;
            3'd4:    src = r_h;
            3'd5:    src = r_l;
            3'd6:    src = r_lo;
            default: src = r_a;
        endcase
        case (y)
            3'd0:    opnd = r_b;
            3'd1:    opnd = r_c;
            3'd2:    opnd = r_d;
            3'd3:    opnd = r_e;
            3'd4:    opnd = r_h;
            3'd5:    opnd = r_l;
            3'd6:    opnd = r_lo;
            default: opnd = r_a;
        endcase
        case (p)
            2'd0:    rp = {r_b, r_c};
            2'd1:    rp = {r_d, r_e};
            2'd2:    rp = hl;
            default: rp = r_sp;
        endcase
        case (y[2:1])
            2'd0:    cond = r_fl.z;
            2'd1:    cond = r_fl.cy;
            2'd2:    cond = r_fl.p;
            default: cond = r_fl.s;
        endcase
        cond = y[0] ? cond : !cond;
        // decimal adjust
        adj    = '0;
        daa_cy = r_fl.cy;
        if (r_fl.ac || r_a[3:0] > 4'd9) begin
            adj = DAA_LO;
        end
        if (r_fl.cy || r_a[7:4] > 4'd9 || (r_a[7:4] >= 4'd9 && r_a[3:0] > 4'd9)) begin
            adj    = adj | DAA_HI;
            daa_cy = 1'b1;
        end
        alu_op = (q == 2'd0) ? ALU_ADD : t_alu_op'(y);
        alu_v  = (q == 2'd0) ? adj : ((q == 2'd3) ? r_b2 : src);
    end

    // data read plan after fetch
    always_comb begin
        ex_ea  = hl;
        ex_nrd = 2'd0;
        unique case (q)
            2'd0: begin
                if (z == 3'd2) begin
                    case (y)
                        3'd1:    begin ex_ea = {r_b, r_c}; ex_nrd = 2'd1; end
                        3'd3:    begin ex_ea = {r_d, r_e}; ex_nrd = 2'd1; end
                        3'd5:    begin ex_ea = imm;        ex_nrd = 2'd2; end
                        3'd7:    begin ex_ea = imm;        ex_nrd = 2'd1; end
                        default: ex_nrd = 2'd0;
                    endcase
                end else if ((z == 3'd4 || z == 3'd5) && y == 3'd6) begin
                    ex_nrd = 2'd1;
                end
            end
            2'd1, 2'd2: begin
                if (z == 3'd6) ex_nrd = 2'd1;
            end
            2'd3: begin
                // returns, pops and XTHL read the two stack bytes
                if (z == 3'd0 || (z == 3'd1 && (!r_op[3] || p == 2'd0)) ||
                    (z == 3'd3 && y == 3'd4)) begin
                    ex_ea  = r_sp;
                    ex_nrd = 2'd2;
                end
            end
        endcase
    end

    // commit: next architectural state and data writes
    always_comb begin
        n_pc = pcn;
        n_sp = r_sp;
        n_a  = r_a;
        n_b  = r_b;
        n_c  = r_c;
        n_d  = r_d;
        n_e  = r_e;
        n_h  = r_h;
        n_l  = r_l;
        n_fl = r_fl;
        n_ie = r_ie;
        w1_we   = 1'b0;
        w1_addr = hl;
        w1_data = r_a;
        w2_we   = 1'b0;
        w2_addr = imm + 16'd1;
        w2_data = r_h;
        rp_we    = 1'b0;
        rp_new   = mdat;
        reg_we   = 1'b0;
        reg_idx  = y;
        reg_val  = r_b2;
        push_we  = 1'b0;
        push_val = pcn;
        v        = opnd;
        dad      = {1'b0, hl} + {1'b0, rp};
        unique case (q)
            2'd0: begin
                case (z)
                    3'd1: begin
                        if (r_op[3]) begin
                            n_h     = dad[15:8];
                            n_l     = dad[7:0];
                            n_fl.cy = dad[16];
                        end else begin
                            rp_we  = 1'b1;
                            rp_new = imm;
                        end
                    end
                    3'd2: begin
                        case (y)
                            3'd0: begin w1_we = 1'b1; w1_addr = {r_b, r_c}; end
                            3'd2: begin w1_we = 1'b1; w1_addr = {r_d, r_e}; end
                            3'd4: begin
                                w1_we = 1'b1; w1_addr = imm; w1_data = r_l;
                                w2_we = 1'b1;
                            end
                            3'd5: begin n_l = r_lo; n_h = r_hi; end
                            3'd6: begin w1_we = 1'b1; w1_addr = imm; end
                            default: n_a = r_lo;
                        endcase
                    end
                    3'd3: begin
                        rp_we  = 1'b1;
                        rp_new = rp + (r_op[3] ? 16'hffff : 16'h0001);
                    end
                    3'd4: begin
                        v       = opnd + 8'd1;
                        n_fl.s  = v[7];
                        n_fl.z  = (v == 8'd0);
                        n_fl.p  = ~^v;
                        n_fl.ac = (v[3:0] == 4'h0);
                        reg_we  = 1'b1;
                        reg_val = v;
                    end
                    3'd5: begin
                        v       = opnd - 8'd1;
                        n_fl.s  = v[7];
                        n_fl.z  = (v == 8'd0);
                        n_fl.p  = ~^v;
                        n_fl.ac = (v[3:0] != 4'hf);
                        reg_we  = 1'b1;
                        reg_val = v;
                    end
                    3'd6: reg_we = 1'b1;
                    3'd7: begin
                        case (y)
                            3'd0: begin n_fl.cy = r_a[7]; n_a = {r_a[6:0], r_a[7]}; end
                            3'd1: begin n_fl.cy = r_a[0]; n_a = {r_a[0], r_a[7:1]}; end
                            3'd2: begin n_fl.cy = r_a[7]; n_a = {r_a[6:0], r_fl.cy}; end
                            3'd3: begin n_fl.cy = r_a[0]; n_a = {r_fl.cy, r_a[7:1]}; end
                            3'd4: begin n_a = alu_res; n_fl = alu_fl; n_fl.cy = daa_cy; end
                            3'd5: n_a = ~r_a;
                            3'd6: n_fl.cy = 1'b1;
                            default: n_fl.cy = !r_fl.cy;
                        endcase
                    end
                    default: n_pc = pcn;
                endcase
            end
            2'd1: begin
                if (r_op != OP_HLT) begin
                    reg_we  = 1'b1;
                    reg_val = src;
                end
            end
            2'd2: begin
                n_a  = (y == 3'd7) ? r_a : alu_res;
                n_fl = alu_fl;
            end
            2'd3: begin
                case (z)
                    3'd0: begin
                        if (cond) begin
                            n_pc = mdat;
                            n_sp = r_sp + 16'd2;
                        end
                    end
                    3'd1: begin
                        if (!r_op[3]) begin
                            n_sp = r_sp + 16'd2;
                            if (p == 2'd3) begin
                                n_a     = r_hi;
                                n_fl.s  = r_lo[7];
                                n_fl.z  = r_lo[6];
                                n_fl.ac = r_lo[4];
                                n_fl.p  = r_lo[2];
                                n_fl.cy = r_lo[0];
                            end else begin
                                rp_we = 1'b1;
                            end
                        end else begin
                            case (p)
                                2'd0: begin n_pc = mdat; n_sp = r_sp + 16'd2; end
                                2'd2: n_pc = hl;
                                2'd3: n_sp = hl;
                                default: n_pc = pcn;
                            endcase
                        end
                    end
                    3'd2: if (cond) n_pc = imm;
                    3'd3: begin
                        case (y)
                            3'd0: n_pc = imm;
                            3'd4: begin
                                n_l = r_lo;
                                n_h = r_hi;
                                w1_we = 1'b1; w1_addr = r_sp; w1_data = r_l;
                                w2_we = 1'b1; w2_addr = r_sp + 16'd1; w2_data = r_h;
                            end
                            3'd5: begin n_h = r_d; n_l = r_e; n_d = r_h; n_e = r_l; end
                            3'd6: n_ie = 1'b0;
                            3'd7: n_ie = 1'b1;
                            default: n_pc = pcn;
                        endcase
                    end
                    3'd4: begin
                        if (cond) begin
                            push_we = 1'b1;
                            n_pc    = imm;
                        end
                    end
                    3'd5: begin
                        if (!r_op[3]) begin
                            push_we  = 1'b1;
                            push_val = (p == 2'd3) ? {r_a, f_flag_byte(r_fl)} : rp;
                        end else if (p == 2'd0) begin
                            push_we = 1'b1;
                            n_pc    = imm;
                        end
                    end
                    3'd6: begin
                        n_a  = (y == 3'd7) ? r_a : alu_res;
                        n_fl = alu_fl;
                    end
                    default: begin
                        push_we = 1'b1;
                        n_pc    = {8'h00, r_op & RST_MASK};
                    end
                endcase
            end
        endcase
        // register pair write-back
        if (rp_we) begin
            case (p)
                2'd0:    begin n_b = rp_new[15:8]; n_c = rp_new[7:0]; end
                2'd1:    begin n_d = rp_new[15:8]; n_e = rp_new[7:0]; end
                2'd2:    begin n_h = rp_new[15:8]; n_l = rp_new[7:0]; end
                default: n_sp = rp_new;
            endcase
        end
        // single register write-back, M goes to memory
        if (reg_we) begin
            case (reg_idx)
                3'd0:    n_b = reg_val;
                3'd1:    n_c = reg_val;
                3'd2:    n_d = reg_val;
                3'd3:    n_e = reg_val;
                3'd4:    n_h = reg_val;
                3'd5:    n_l = reg_val;
                3'd6:    begin w1_we = 1'b1; w1_addr = hl; w1_data = reg_val; end
                default: n_a = reg_val;
            endcase
        end
        // stack push: high byte first
        if (push_we) begin
            n_sp    = r_sp - 16'd2;
            w1_we   = 1'b1;
            w1_addr = r_sp - 16'd1;
            w1_data = push_val[15:8];
            w2_we   = 1'b1;
            w2_addr = r_sp - 16'd2;
            w2_data = push_val[7:0];
        end
    end

    // memory port select
    always_comb begin
        ram_req.we    = 1'b0;
        ram_req.addr  = r_pc[MEM_AW-1:0];
        ram_req.wdata = w1_data;
        unique case (r_state)
            S_IDLE: begin
                if (in_beat && t_cmd'(i_in.cmd) != CMD_EXEC) begin
                    ram_req.we    = (t_cmd'(i_in.cmd) == CMD_WRITE);
                    ram_req.addr  = i_in.mem_addr[MEM_AW-1:0];
                    ram_req.wdata = i_in.mem_wdata;
                end
            end
            S_OP: begin
                ram_req.addr = 16'(r_pc + 16'd1) & 16'((1 << MEM_AW) - 1);
            end
            S_B2: begin
                ram_req.addr = 16'(r_pc + 16'd2) & 16'((1 << MEM_AW) - 1);
            end
            S_EX:  ram_req.addr = ex_ea[MEM_AW-1:0];
            S_R1:  ram_req.addr = 16'(r_ea + 16'd1) & 16'((1 << MEM_AW) - 1);
            S_COM: begin
                ram_req.we   = w1_we;
                ram_req.addr = w1_addr[MEM_AW-1:0];
            end
            S_W2: begin
                ram_req.we    = 1'b1;
                ram_req.addr  = r_wa2[MEM_AW-1:0];
                ram_req.wdata = r_wd2;
            end
            default: ram_req.we = 1'b0;
        endcase
    end

    // sequencer, architectural state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pc    <= '0;
            r_sp    <= '0;
            r_a     <= '0;
            r_b     <= '0;
            r_c     <= '0;
            r_d     <= '0;
            r_e     <= '0;
            r_h     <= '0;
            r_l     <= '0;
            r_fl    <= '0;
            r_ie    <= 1'b0;
        end else begin
            // output beat taken; the done state reloads it itself
            if (r_ov && o_res.ready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_rbyte <= '0;
                        unique case (t_cmd'(i_in.cmd))
                            CMD_READ: r_state <= S_RDB;
                            CMD_EXEC: r_state <= S_OP;
                            CMD_WRITE, CMD_NONE: r_state <= S_DONE;
                        endcase
                    end
                end
                S_RDB: begin
                    r_rbyte <= ram_rdata;
                    r_state <= S_DONE;
                end
                S_OP: begin
                    r_op    <= ram_rdata;
                    r_state <= (f_len(ram_rdata) != 2'd1) ? S_B2 : S_EX;
                end
                S_B2: begin
                    r_b2    <= ram_rdata;
                    r_state <= (f_len(r_op) == 2'd3) ? S_B3 : S_EX;
                end
                S_B3: begin
                    r_b3    <= ram_rdata;
                    r_state <= S_EX;
                end
                S_EX: begin
                    r_ea    <= ex_ea;
                    r_rd2   <= (ex_nrd == 2'd2);
                    r_state <= (ex_nrd != 2'd0) ? S_R1 : S_COM;
                end
                S_R1: begin
                    r_lo    <= ram_rdata;
                    r_state <= r_rd2 ? S_R2 : S_COM;
                end
                S_R2: begin
                    r_hi    <= ram_rdata;
                    r_state <= S_COM;
                end
                S_COM: begin
                    r_pc    <= n_pc;
                    r_sp    <= n_sp;
                    r_a     <= n_a;
                    r_b     <= n_b;
                    r_c     <= n_c;
                    r_d     <= n_d;
                    r_e     <= n_e;
                    r_h     <= n_h;
                    r_l     <= n_l;
                    r_fl    <= n_fl;
                    r_ie    <= n_ie;
                    r_wa2   <= w2_addr;
                    r_wd2   <= w2_data;
                    r_state <= w2_we ? S_W2 : S_DONE;
                end
                S_W2: r_state <= S_DONE;
                S_DONE: begin
                    if (!r_ov || o_res.ready) begin
                        r_res.pc <= r_pc;
                        r_res.sp <= r_sp;
                        r_res.a  <= r_a;
                        r_res.b  <= r_b;
                        r_res.c  <= r_c;
                        r_res.d  <= r_d;
                        r_res.e  <= r_e;
                        r_res.h  <= r_h;
                        r_res.l  <= r_l;
                        r_res.fb <= f_flag_byte(r_fl);
                        r_res.ie <= r_ie;
                        r_res.rb <= r_rbyte;
                        r_ov     <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid        = r_ov;
    assign o_res.pc_value     = r_res.pc;
    assign o_res.sp_value     = r_res.sp;
    assign o_res.a_value      = r_res.a;
    assign o_res.b_value      = r_res.b;
    assign o_res.c_value      = r_res.c;
    assign o_res.d_value      = r_res.d;
    assign o_res.e_value      = r_res.e;
    assign o_res.h_value      = r_res.h;
    assign o_res.l_value      = r_res.l;
    assign o_res.flag_byte    = r_res.fb;
    assign o_res.ints_enabled = r_res.ie;
    assign o_res.read_byte    = r_res.rb;

`ifndef SYNTH
    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_busy |-> !i_in.ready)
        else $error("beat accepted during memory clear");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !i_in.ready)
        else $error("second beat accepted while a command is in flight");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done state");

    a_sp_commit_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_COM) |=> $stable(r_sp))
        else $error("stack pointer changed outside commit");
`endif

endmodule

// ===== test/cpu8080_instruction_execute_unit_test.sv =====
module cpu8080_instruction_execute_unit_test;
    import cie_pkg::*;

    localparam int WATCHDOG_LIMIT = 400000;
    localparam int SETTLE_CYCLES  = 24;

    // Register file snapshot carried by one result beat
    typedef struct {
        logic [15:0] pc;
        logic [15:0] sp;
        logic [7:0]  a, b, c, d, e, h, l;
        logic [7:0]  fb;
        logic        ie;
        logic [7:0]  rb;
    } cpu_state_t;

    logic i_clk;
    logic i_rst_n;

    cie_in_if  in_ch();
    cie_out_if res_ch();

    cpu8080_instruction_execute_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_res  (res_ch)
    );

    // Shadow processor state
    logic [15:0] sh_pc, sh_sp;
    logic [7:0]  sh_a;
    logic [7:0]  sh_r [6];
    t_flags      sh_f;
    logic        sh_ie;
    logic [7:0]  mem_image [MEM_BYTES];

    cpu_state_t pending_states [$];
    int err_count;
    int checked_count;
    int exec_count;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    // Clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------- shadow processor ----------------
    function automatic logic [7:0] fetch8();
        logic [7:0] v;
        v = mem_image[sh_pc];
        sh_pc = sh_pc + 16'd1;
        return v;
    endfunction

    function automatic logic [15:0] fetch16();
        logic [7:0] lo;
        logic [7:0] hi;
        lo = fetch8();
        hi = fetch8();
        return {hi, lo};
    endfunction

    function automatic void set_szp(logic [7:0] v);
        sh_f.s = v[7];
        sh_f.z = (v == 8'd0);
        sh_f.p = ~^v;
    endfunction

    function automatic logic [15:0] hl_addr();
        return {sh_r[4], sh_r[5]};
    endfunction

    // Register operand 6 is memory at HL, 7 is A
    function automatic logic [7:0] get_reg(logic [2:0] r);
        if (r == 3'd6) return mem_image[hl_addr()];
        if (r == 3'd7) return sh_a;
        return sh_r[r];
    endfunction

    function automatic void set_reg(logic [2:0] r, logic [7:0] v);
        if (r == 3'd6) mem_image[hl_addr()] = v;
        else if (r == 3'd7) sh_a = v;
        else sh_r[r] = v;
    endfunction

    function automatic logic [15:0] get_pair(logic [1:0] p);
        if (p == 2'd3) return sh_sp;
        return {sh_r[2*p], sh_r[2*p+1]};
    endfunction

    function automatic void set_pair(logic [1:0] p, logic [15:0] v);
        if (p == 2'd3) sh_sp = v;
        else begin
            sh_r[2*p]   = v[15:8];
            sh_r[2*p+1] = v[7:0];
        end
    endfunction

    function automatic logic [7:0] psw_flags();
        return {sh_f.s, sh_f.z, 1'b0, sh_f.ac, 1'b0, sh_f.p, 1'b1, sh_f.cy};
    endfunction

    function automatic void push_word(logic [15:0] v);
        sh_sp = sh_sp - 16'd1;
        mem_image[sh_sp] = v[15:8];
        sh_sp = sh_sp - 16'd1;
        mem_image[sh_sp] = v[7:0];
    endfunction

    function automatic logic [15:0] pop_word();
        logic [7:0] lo;
        logic [7:0] hi;
        lo = mem_image[sh_sp];
        hi = mem_image[sh_sp + 16'd1];
        sh_sp = sh_sp + 16'd2;
        return {hi, lo};
    endfunction

    function automatic void alu_apply(t_alu_op op, logic [7:0] v);
        logic [8:0] wide;
        logic [8:0] sub;
        logic [7:0] res;
        logic [2:0] idx;
        case (op)
            ALU_ADD, ALU_ADC: begin
                wide = {1'b0, sh_a} + {1'b0, v} + ((op == ALU_ADC) ? sh_f.cy : 1'b0);
                res = wide[7:0];
                idx = {sh_a[3], v[3], res[3]};
                sh_f.ac = ADD_HC[idx];
                sh_f.cy = wide[8];
            end
            ALU_SUB, ALU_SBB, ALU_CMP: begin
                sub = {1'b0, v} + ((op == ALU_SBB) ? sh_f.cy : 1'b0);
                res = sh_a - sub[7:0];
                idx = {sh_a[3], v[3], res[3]};
                // AC is the inverted borrow out of bit 3
                sh_f.ac = ~SUB_HB[idx];
                sh_f.cy = ({1'b0, sh_a} < sub);
            end
            ALU_ANA: begin
                sh_f.ac = sh_a[3] | v[3];
                res = sh_a & v;
                sh_f.cy = 1'b0;
            end
            default: begin
                res = (op == ALU_XRA) ? (sh_a ^ v) : (sh_a | v);
                sh_f.ac = 1'b0;
                sh_f.cy = 1'b0;
            end
        endcase
        set_szp(res);
        if (op != ALU_CMP) sh_a = res;
    endfunction

    function automatic logic cond_met(logic [2:0] cc);
        logic f;
        case (cc[2:1])
            2'd0: f = sh_f.z;
            2'd1: f = sh_f.cy;
            2'd2: f = sh_f.p;
            default: f = sh_f.s;
        endcase
        return cc[0] ? f : ~f;
    endfunction

    function automatic void decimal_adjust();
        logic [7:0] adj;
        logic       cy;
        logic [3:0] lo;
        logic [3:0] hi;
        adj = 8'd0;
        cy = sh_f.cy;
        lo = sh_a[3:0];
        hi = sh_a[7:4];
        if (sh_f.ac || lo > 4'd9) adj = DAA_LO;
        if (cy || hi > 4'd9 || (hi >= 4'd9 && lo > 4'd9)) begin
            adj = adj | DAA_HI;
            cy = 1'b1;
        end
        alu_apply(ALU_ADD, adj);
        sh_f.cy = cy;
    endfunction

    function automatic void exec_low(logic [7:0] op);
        logic [2:0]  y;
        logic [1:0]  p;
        logic [15:0] a;
        logic [16:0] s17;
        logic [7:0]  v;
        y = op[5:3];
        p = op[5:4];
        case (op[2:0])
            3'd1: begin
                if (op[3]) begin
                    s17 = {1'b0, hl_addr()} + {1'b0, get_pair(p)};
                    set_pair(2'd2, s17[15:0]);
                    sh_f.cy = s17[16];
                end else begin
                    set_pair(p, fetch16());
                end
            end
            3'd2: begin
                case (y)
                    3'd0: mem_image[get_pair(2'd0)] = sh_a;
                    3'd1: sh_a = mem_image[get_pair(2'd0)];
                    3'd2: mem_image[get_pair(2'd1)] = sh_a;
                    3'd3: sh_a = mem_image[get_pair(2'd1)];
                    3'd4: begin
                        a = fetch16();
                        mem_image[a] = sh_r[5];
                        mem_image[a + 16'd1] = sh_r[4];
                    end
                    3'd5: begin
                        a = fetch16();
                        sh_r[5] = mem_image[a];
                        sh_r[4] = mem_image[a + 16'd1];
                    end
                    3'd6: begin
                        a = fetch16();
                        mem_image[a] = sh_a;
                    end
                    default: begin
                        a = fetch16();
                        sh_a = mem_image[a];
                    end
                endcase
            end
            3'd3: set_pair(p, get_pair(p) + (op[3] ? 16'hffff : 16'd1));
            3'd4: begin
                v = get_reg(y) + 8'd1;
                set_szp(v);
                sh_f.ac = (v[3:0] == 4'h0);
                set_reg(y, v);
            end
            3'd5: begin
                v = get_reg(y) - 8'd1;
                set_szp(v);
                sh_f.ac = (v[3:0] != 4'hf);
                set_reg(y, v);
            end
            3'd6: begin
                v = fetch8();
                set_reg(y, v);
            end
            3'd7: begin
                case (y)
                    3'd0: begin sh_f.cy = sh_a[7]; sh_a = {sh_a[6:0], sh_a[7]}; end
                    3'd1: begin sh_f.cy = sh_a[0]; sh_a = {sh_a[0], sh_a[7:1]}; end
                    3'd2: begin
                        v = {7'd0, sh_f.cy};
                        sh_f.cy = sh_a[7];
                        sh_a = {sh_a[6:0], v[0]};
                    end
                    3'd3: begin
                        v = {7'd0, sh_f.cy};
                        sh_f.cy = sh_a[0];
                        sh_a = {v[0], sh_a[7:1]};
                    end
                    3'd4: decimal_adjust();
                    3'd5: sh_a = ~sh_a;
                    3'd6: sh_f.cy = 1'b1;
                    default: sh_f.cy = ~sh_f.cy;
                endcase
            end
            default: ;
        endcase
    endfunction

    function automatic void exec_high(logic [7:0] op);
        logic [2:0]  y;
        logic [1:0]  p;
        logic [15:0] a;
        logic [7:0]  t;
        y = op[5:3];
        p = op[5:4];
        case (op[2:0])
            3'd0: if (cond_met(y)) sh_pc = pop_word();
            3'd1: begin
                if (!op[3]) begin
                    a = pop_word();
                    if (p == 2'd3) begin
                        sh_a = a[15:8];
                        sh_f.s  = a[7];
                        sh_f.z  = a[6];
                        sh_f.ac = a[4];
                        sh_f.p  = a[2];
                        sh_f.cy = a[0];
                    end else begin
                        set_pair(p, a);
                    end
                end else if (p == 2'd0) sh_pc = pop_word();
                else if (p == 2'd2) sh_pc = hl_addr();
                else if (p == 2'd3) sh_sp = hl_addr();
            end
            3'd2: begin
                a = fetch16();
                if (cond_met(y)) sh_pc = a;
            end
            3'd3: begin
                case (y)
                    3'd0: sh_pc = fetch16();
                    3'd2, 3'd3: t = fetch8();   // port byte skipped
                    3'd4: begin
                        t = mem_image[sh_sp];
                        mem_image[sh_sp] = sh_r[5];
                        sh_r[5] = t;
                        a = sh_sp + 16'd1;
                        t = mem_image[a];
                        mem_image[a] = sh_r[4];
                        sh_r[4] = t;
                    end
                    3'd5: begin
                        t = sh_r[4]; sh_r[4] = sh_r[2]; sh_r[2] = t;
                        t = sh_r[5]; sh_r[5] = sh_r[3]; sh_r[3] = t;
                    end
                    3'd6: sh_ie = 1'b0;
                    3'd7: sh_ie = 1'b1;
                    default: ;
                endcase
            end
            3'd4: begin
                a = fetch16();
                if (cond_met(y)) begin
                    push_word(sh_pc);
                    sh_pc = a;
                end
            end
            3'd5: begin
                if (!op[3]) push_word((p == 2'd3) ? {sh_a, psw_flags()} : get_pair(p));
                else if (p == 2'd0) begin
                    a = fetch16();
                    push_word(sh_pc);
                    sh_pc = a;
                end
            end
            3'd6: begin
                t = fetch8();
                alu_apply(t_alu_op'(y), t);
            end
            default: begin
                // restart pushes the address of the next instruction
                push_word(sh_pc);
                sh_pc = {8'd0, op & RST_MASK};
            end
        endcase
    endfunction

    // Apply one accepted command and queue the result it should produce
    function automatic void cpu_apply(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wdata);
        cpu_state_t st;
        logic [7:0] op;
        logic [7:0] rb;
        rb = 8'd0;
        if (cmd == CMD_WRITE) mem_image[addr] = wdata;
        else if (cmd == CMD_READ) rb = mem_image[addr];
        else if (cmd == CMD_EXEC) begin
            op = fetch8();
            case (op[7:6])
                2'd0: exec_low(op);
                2'd1: if (op != OP_HLT) set_reg(op[5:3], get_reg(op[2:0]));
                2'd2: alu_apply(t_alu_op'(op[5:3]), get_reg(op[2:0]));
                default: exec_high(op);
            endcase
        end
        st.pc = sh_pc;
        st.sp = sh_sp;
        st.a  = sh_a;
        st.b  = sh_r[0];
        st.c  = sh_r[1];
        st.d  = sh_r[2];
        st.e  = sh_r[3];
        st.h  = sh_r[4];
        st.l  = sh_r[5];
        st.fb = psw_flags();
        st.ie = sh_ie;
        st.rb = rb;
        pending_states.push_back(st);
    endfunction

    // ---------------- result checking ----------------
    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= 40)
            $display("result %0d: %s got %h want %h", checked_count, what, got, want);
    endtask

    task automatic check_field(string what, int got, int want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin
        cpu_state_t w;
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (pending_states.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                w = pending_states.pop_front();
                check_field("pc", res_ch.pc_value, w.pc);
                check_field("sp", res_ch.sp_value, w.sp);
                check_field("A", res_ch.a_value, w.a);
                check_field("B", res_ch.b_value, w.b);
                check_field("C", res_ch.c_value, w.c);
                check_field("D", res_ch.d_value, w.d);
                check_field("E", res_ch.e_value, w.e);
                check_field("H", res_ch.h_value, w.h);
                check_field("L", res_ch.l_value, w.l);
                check_field("flags", res_ch.flag_byte, w.fb);
                check_field("int enable", res_ch.ints_enabled, w.ie);
                check_field("read byte", res_ch.read_byte, w.rb);
            end
            checked_count++;
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_states.size());
            $display("cpu8080_instruction_execute_unit: mismatch");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_cmd(logic [1:0] cmd, logic [15:0] addr, logic [7:0] wdata);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.cmd       <= cmd;
        in_ch.mem_addr  <= addr;
        in_ch.mem_wdata <= wdata;
        do @(posedge i_clk); while (!in_ch.ready);
        cpu_apply(cmd, addr, wdata);
        if (cmd == CMD_EXEC) exec_count++;
    endtask

    // Place an instruction with two operand bytes at pc and execute it
    task automatic run_instr(logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
        logic [15:0] at;
        at = sh_pc;
        send_cmd(CMD_WRITE, at, op);
        send_cmd(CMD_WRITE, at + 16'd1, b1);
        send_cmd(CMD_WRITE, at + 16'd2, b2);
        send_cmd(CMD_EXEC, 16'd0, 8'd0);
    endtask

    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (pending_states.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_cmd(CMD_WRITE, 16'hffff, 8'hff);
        send_cmd(CMD_READ, 16'hffff, 8'h00);
        send_cmd(CMD_READ, 16'h0000, 8'h00);
        send_cmd(CMD_NONE, 16'hffff, 8'hff);
        // MVI A,FF then ADI 01: carry and half carry out
        run_instr(8'h3e, 8'hff, 8'h00);
        run_instr(8'hc6, 8'h01, 8'h00);
        // decimal adjust with both carries set, then a restart
        run_instr(8'h27, 8'h00, 8'h00);
        run_instr(8'hff, 8'h00, 8'h00);
    endtask

    task automatic test_special_ops();
        run_instr(8'hfb, 8'h00, 8'h00);   // EI
        run_instr(8'h76, 8'h00, 8'h00);   // halt acts as no-op
        run_instr(8'hdb, 8'h12, 8'h00);   // IN skips port byte
        run_instr(8'hd3, 8'h34, 8'h00);   // OUT
        run_instr(8'hdd, 8'h00, 8'h00);   // undocumented no-op
        run_instr(8'hf3, 8'h00, 8'h00);   // DI
        run_instr(8'hd6, 8'h01, 8'h00);   // SUI, no half borrow
    endtask

    task automatic test_random_phase(int seqs);
        int k;
        for (k = 0; k < seqs; k++) begin
            if ($urandom_range(9) == 0)
                send_cmd(2'($urandom_range(3)), 16'($urandom), 8'($urandom));
            else
                run_instr(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        err_count = 0;
        checked_count = 0;
        exec_count = 0;
        quiet_cycles = 0;
        send_idle_pct = 20;
        recv_idle_pct = 52;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CMD_NONE;
        in_ch.mem_addr = 16'd0;
        in_ch.mem_wdata = 8'd0;
        res_ch.ready = 1'b0;
        sh_pc = 16'd0;
        sh_sp = 16'd0;
        sh_a = 8'd0;
        foreach (sh_r[i]) sh_r[i] = 8'd0;
        sh_f = '0;
        sh_ie = 1'b0;
        foreach (mem_image[i]) mem_image[i] = 8'd0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_special_ops();
        test_random_phase(50);
        // hold off until every result is back
        drain_results();
        send_idle_pct = 52;
        recv_idle_pct = 20;
        test_random_phase(50);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_phase(50);

        drain_results();
        $display("covered %0d beats checked, %0d instructions executed", checked_count,
                 exec_count);
        $display("memory access, unused command and random opcodes under three idle mixes");
        if (err_count == 0) begin
            $display("cpu8080_instruction_execute_unit: match");
        end else begin
            $display("%0d mismatches", err_count);
            $display("cpu8080_instruction_execute_unit: mismatch");
        end
        $finish;
    end

endmodule
